### rtl/core/rita_pkg.sv
// Shared constants, command/status structs and the digit glyph function
// for the radix integer-to-ASCII converter. No dependencies.
package rita_pkg;

   localparam int VALUE_W    = 64;   // width of the value field on the request channel
   localparam int RADIX_W    = 8;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;

   localparam int VALUE_BITS = 64;   // 8 to 64
   localparam int MAX_DIGITS = 64;   // 8 to 64

   localparam int NARROW_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
   localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W       = $clog2(MAX_DIGITS);
   localparam int DIV_CNT_W   = $clog2(VALUE_BITS);

   localparam int HEX_WIDE_RAW   = (VALUE_BITS + 3) / 4;
   localparam int HEX_NARROW_RAW = (NARROW_BITS + 3) / 4;
   localparam int HEX_WIDE   = (HEX_WIDE_RAW > MAX_DIGITS) ? MAX_DIGITS : HEX_WIDE_RAW;
   localparam int HEX_NARROW = (HEX_NARROW_RAW > MAX_DIGITS) ? MAX_DIGITS : HEX_NARROW_RAW;
   localparam int BIN_WIDE   = (VALUE_BITS > MAX_DIGITS) ? MAX_DIGITS : VALUE_BITS;
   localparam int BIN_NARROW = (NARROW_BITS > MAX_DIGITS) ? MAX_DIGITS : NARROW_BITS;

   localparam logic [RADIX_W-1:0] RADIX_BIN = 8'd2;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 8'd16;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h37;  // 'A' - 10

   // Controller to datapath
   typedef struct packed {
      logic load;         // capture the request item
      logic div_start;    // clear remainder and step counter
      logic div_step;     // one restoring-division step
      logic div_store;    // write remainder as next digit
      logic shift_store;  // write low bits as next digit, shift quotient
      logic emit_start;   // point read index at the top digit
      logic emit_next;    // step read index down
   } rita_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic radix_ok;
      logic radix_pow2;
      logic div_last;
      logic q_zero;
      logic n_last;
      logic e_zero;
   } rita_sts_type;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      return (d < 4'd10) ? (CHAR_ZERO + ext) : (CHAR_LETTER + ext);
   endfunction

endpackage

### rtl/core/rita_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on rita_pkg for field widths.
interface rita_req_if;
   logic                            valid;
   logic                            ready;
   logic [rita_pkg::VALUE_W-1:0]    value;
   logic [rita_pkg::RADIX_W-1:0]    radix;
   logic                            wide_mode;

   modport source (output valid, output value, output radix, output wide_mode, input ready);
   modport sink   (input valid, input value, input radix, input wide_mode, output ready);
endinterface

interface rita_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rita_pkg::CHAR_W-1:0]     ascii_char;
   logic                            last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

### rtl/core/radix_integer_to_ascii.sv
// Top level of the radix integer-to-ASCII converter: controller plus datapath.
// Depends on rita_pkg, rita_req_if/rita_rsp_if, rita_ctrl and rita_dp.
//
//   channel | direction | payload                       | one item is
//   req_ch  | in        | value[64], radix[8], wide_mode | one number to convert
//   rsp_ch  | out       | ascii_char[7], last_char       | one character, MSD first
//
// Radix 2 and 16 produce one digit per cycle by shifting the quotient. Other
// radices run a bit-serial restoring divider, one step per quotient bit, then
// store the remainder as a digit (at most 41 digits). Each character is read
// through the digit memory's registered read port in LOAD and offered in SEND
// until the response side takes it. Invalid radices (0, 1, above 16) retire
// from CHECK with no characters. One item is in flight at a time; a new
// request is taken only after the last character has been delivered.
// Reset is synchronous and active high; the digit memory is not cleared.
module radix_integer_to_ascii (
   input  logic            clock,
   input  logic            reset,
   rita_req_if.sink        req_ch,
   rita_rsp_if.source      rsp_ch
);

   rita_pkg::rita_cmd_type cmd;
   rita_pkg::rita_sts_type sts;

   // Sequence the conversion and the character stream.
   rita_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   // Hold the quotient, produce digits, replay them most significant first.
   rita_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (req_ch.value),
      .radix      (req_ch.radix),
      .wide_mode  (req_ch.wide_mode),
      .sts        (sts),
      .ascii_char (rsp_ch.ascii_char),
      .last_char  (rsp_ch.last_char)
   );

   // Never offer a character while a new request may be taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("response valid while request ready");

   // An accepted request drops ready on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready held after accepting an item");

   // Delivering the final character returns the block to idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_char) |=> (req_ch.ready && !rsp_ch.valid))
      else $error("block not idle after last character");

   // Every offered character is a valid digit glyph.
   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.ascii_char >= 7'h30 && rsp_ch.ascii_char <= 7'h39) ||
                        (rsp_ch.ascii_char >= 7'h41 && rsp_ch.ascii_char <= 7'h46)))
      else $error("character outside digit glyph set");

endmodule

### rtl/core/rita_dp.sv
// Datapath: quotient register, bit-serial divider, digit memory, emit index.
// Depends on rita_pkg.
module rita_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  rita_pkg::rita_cmd_type         cmd,
   input  logic [rita_pkg::VALUE_W-1:0]   value,
   input  logic [rita_pkg::RADIX_W-1:0]   radix,
   input  logic                           wide_mode,
   output rita_pkg::rita_sts_type         sts,
   output logic [rita_pkg::CHAR_W-1:0]    ascii_char,
   output logic                           last_char
);

   localparam int VB = rita_pkg::VALUE_BITS;
   localparam logic [VB-1:0] NARROW_MASK = {VB{1'b1}} >> (VB - rita_pkg::NARROW_BITS);

   logic [VB-1:0]                     q_ff, q_in;
   logic [rita_pkg::DIGIT_W-1:0]      rem_ff, rem_in;
   logic [rita_pkg::RADIX_W-1:0]      radix_ff;
   logic [rita_pkg::DIV_CNT_W-1:0]    bitcnt_ff, bitcnt_in;
   logic [rita_pkg::CNT_W-1:0]        n_ff, n_in, total_ff, total_in;
   logic [rita_pkg::IDX_W-1:0]        e_ff, e_in;
   logic [rita_pkg::DIGIT_W-1:0]      rd_ff;
   logic [rita_pkg::DIGIT_W-1:0]      mem [rita_pkg::MAX_DIGITS];

   logic [rita_pkg::DIGIT_W:0]        trial;
   logic                              ge;
   logic                              is_hex;
   logic [rita_pkg::DIGIT_W-1:0]      shift_digit;

   assign is_hex      = (radix_ff == rita_pkg::RADIX_HEX);
   assign shift_digit = is_hex ? q_ff[rita_pkg::DIGIT_W-1:0]
                               : {{(rita_pkg::DIGIT_W-1){1'b0}}, q_ff[0]};

   // Restoring division step: remainder stays below the radix.
   assign trial = {rem_ff, q_ff[VB-1]};
   assign ge    = (trial >= radix_ff[rita_pkg::DIGIT_W:0]);

   always_comb begin
      q_in      = q_ff;
      rem_in    = rem_ff;
      bitcnt_in = bitcnt_ff;
      n_in      = n_ff;
      total_in  = total_ff;
      e_in      = e_ff;
      if (cmd.load) begin
         q_in = value[VB-1:0] & (wide_mode ? {VB{1'b1}} : NARROW_MASK);
         n_in = '0;
         if (radix == rita_pkg::RADIX_HEX) begin
            total_in = wide_mode ? rita_pkg::CNT_W'(rita_pkg::HEX_WIDE)
                                 : rita_pkg::CNT_W'(rita_pkg::HEX_NARROW);
         end else if (radix == rita_pkg::RADIX_BIN) begin
            total_in = wide_mode ? rita_pkg::CNT_W'(rita_pkg::BIN_WIDE)
                                 : rita_pkg::CNT_W'(rita_pkg::BIN_NARROW);
         end else begin
            total_in = rita_pkg::CNT_W'(rita_pkg::MAX_DIGITS);
         end
      end
      if (cmd.div_step) begin
         q_in      = {q_ff[VB-2:0], ge};
         rem_in    = ge ? rita_pkg::DIGIT_W'(trial - radix_ff[rita_pkg::DIGIT_W:0])
                        : trial[rita_pkg::DIGIT_W-1:0];
         bitcnt_in = bitcnt_ff + rita_pkg::DIV_CNT_W'(1);
      end
      if (cmd.shift_store) begin
         q_in = is_hex ? (q_ff >> 4) : (q_ff >> 1);
      end
      if (cmd.div_store || cmd.shift_store) begin
         n_in = n_ff + rita_pkg::CNT_W'(1);
      end
      if (cmd.div_start) begin
         rem_in    = '0;
         bitcnt_in = '0;
      end
      if (cmd.emit_start) begin
         e_in = rita_pkg::IDX_W'(n_ff - rita_pkg::CNT_W'(1));
      end
      if (cmd.emit_next) begin
         e_in = e_ff - rita_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff      <= '0;
         bitcnt_ff <= '0;
         n_ff      <= '0;
         total_ff  <= '0;
         e_ff      <= '0;
      end else begin
         q_ff      <= q_in;
         bitcnt_ff <= bitcnt_in;
         n_ff      <= n_in;
         total_ff  <= total_in;
         e_ff      <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (cmd.load) begin
         radix_ff <= radix;
      end
   end

   // Digit memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         mem[n_ff[rita_pkg::IDX_W-1:0]] <= rem_ff;
      end else if (cmd.shift_store) begin
         mem[n_ff[rita_pkg::IDX_W-1:0]] <= shift_digit;
      end
      rd_ff <= mem[e_ff];
   end

   assign sts.radix_ok   = (radix_ff >= rita_pkg::RADIX_BIN) && (radix_ff <= rita_pkg::RADIX_HEX);
   assign sts.radix_pow2 = (radix_ff == rita_pkg::RADIX_BIN) || is_hex;
   assign sts.div_last   = (bitcnt_ff == rita_pkg::DIV_CNT_W'(VB - 1));
   assign sts.q_zero     = (q_ff == '0);
   assign sts.n_last     = ((n_ff + rita_pkg::CNT_W'(1)) == total_ff);
   assign sts.e_zero     = (e_ff == '0);

   assign ascii_char = rita_pkg::digit_glyph(rd_ff);
   assign last_char  = (e_ff == '0);

endmodule

### rtl/core/rita_ctrl.sv
// Controller state machine: sequences conversion and character emission.
// Depends on rita_pkg; drives the datapath through rita_cmd_type.
module rita_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     rsp_ready,
   input  rita_pkg::rita_sts_type   sts,
   output logic                     req_ready,
   output logic                     rsp_valid,
   output rita_pkg::rita_cmd_type   cmd
);

   typedef enum logic [2:0] {
      IDLE, CHECK, SHIFT, DIV, STORE, EMIT_START, LOAD, SEND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (!sts.radix_ok) begin
               state_in = IDLE;
            end else if (sts.radix_pow2) begin
               state_in = SHIFT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = DIV;
            end
         end
         SHIFT: begin
            cmd.shift_store = 1'b1;
            if (sts.n_last) begin
               state_in = EMIT_START;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = STORE;
            end
         end
         STORE: begin
            cmd.div_store = 1'b1;
            cmd.div_start = 1'b1;
            if (sts.q_zero || sts.n_last) begin
               state_in = EMIT_START;
            end else begin
               state_in = DIV;
            end
         end
         EMIT_START: begin
            cmd.emit_start = 1'b1;
            state_in       = LOAD;
         end
         LOAD: begin
            state_in = SEND;
         end
         SEND: begin
            if (rsp_ready && valid_ff) begin
               if (sts.e_zero) begin
                  state_in = IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = LOAD;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
         valid_ff <= (state_in == SEND);
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

endmodule

### tb/sv/rita_char_checker.sv
// Scoreboard for the radix integer-to-ASCII converter: watches both channels,
// predicts each number's characters and compares them in order.
// Depends on rita_pkg and the rita_req_if/rita_rsp_if interfaces.
module rita_char_checker (
   input  logic  clock,
   input  logic  reset,
   rita_req_if   req_mon,
   rita_rsp_if   rsp_mon,
   output int    mismatch_count,
   output int    chars_outstanding,
   output int    chars_seen
);

   typedef struct packed {
      logic [rita_pkg::CHAR_W-1:0] glyph;
      logic                        last;
   } char_item_type;

   char_item_type pending_chars[$];
   string         glyph_row = "0123456789ABCDEF";

   // Queue the characters one number should produce, most significant first.
   task automatic predict_digits(input logic [rita_pkg::VALUE_W-1:0] value,
                                 input logic [rita_pkg::RADIX_W-1:0] radix,
                                 input logic                         wide);
      logic [rita_pkg::DIGIT_W-1:0] digits [rita_pkg::MAX_DIGITS];
      logic [rita_pkg::VALUE_W-1:0] quot;
      int                           width;
      int                           total;
      int                           n;
      int                           k;
      char_item_type                item;
      width = wide ? rita_pkg::VALUE_BITS : rita_pkg::NARROW_BITS;
      if (radix < rita_pkg::RADIX_BIN || radix > rita_pkg::RADIX_HEX) return;
      quot = (width >= rita_pkg::VALUE_W) ? value : value & ((64'd1 << width) - 64'd1);
      n = 0;
      if (radix == rita_pkg::RADIX_HEX || radix == rita_pkg::RADIX_BIN) begin
         total = (radix == rita_pkg::RADIX_HEX) ? (width + 3) / 4 : width;
         if (total > rita_pkg::MAX_DIGITS) total = rita_pkg::MAX_DIGITS;
         while (n < total) begin
            digits[n] = (radix == rita_pkg::RADIX_HEX) ? quot[3:0] : {3'b000, quot[0]};
            quot = (radix == rita_pkg::RADIX_HEX) ? quot >> 4 : quot >> 1;
            n++;
         end
      end else begin
         do begin
            digits[n] = rita_pkg::DIGIT_W'(quot % radix);
            quot = quot / radix;
            n++;
         end while (quot != 0 && n < rita_pkg::MAX_DIGITS);
      end
      for (k = 0; k < n; k++) begin
         item.glyph = rita_pkg::CHAR_W'(glyph_row[digits[n - 1 - k]]);
         item.last  = (k == n - 1);
         pending_chars.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      char_item_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            predict_digits(req_mon.value, req_mon.radix, req_mon.wide_mode);
         if (rsp_mon.valid && rsp_mon.ready) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected character %h last %b", rsp_mon.ascii_char,
                           rsp_mon.last_char);
               mismatch_count++;
            end else begin
               want = pending_chars.pop_front();
               if (want.glyph != rsp_mon.ascii_char || want.last != rsp_mon.last_char) begin
                  if (mismatch_count < 10)
                     $display("character mismatch: expected %h last %b, got %h last %b",
                              want.glyph, want.last, rsp_mon.ascii_char, rsp_mon.last_char);
                  mismatch_count++;
               end
            end
         end
      end
      chars_outstanding = pending_chars.size();
   end

endmodule

### tb/sv/tb_top.sv
// Top of the radix integer-to-ASCII testbench: clock, reset, request and
// response drivers and the verdict. Depends on rita_pkg, the channel
// interfaces, radix_integer_to_ascii and rita_char_checker.
module tb_top;

   logic clock;
   logic reset;

   int mismatch_count;
   int chars_outstanding;
   int chars_seen;

   int numbers_sent;
   int numbers_rejected;
   int random_converted;
   bit calm_send;
   bit calm_recv;

   rita_req_if req_ch ();
   rita_rsp_if rsp_ch ();

   radix_integer_to_ascii u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rita_char_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding),
      .chars_seen        (chars_seen)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Draw an idle count for one item; a calm stretch forces back-to-back items.
   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // Mix of value shapes: full random, small, all ones, one-hot, and a
   // saturated low half under random upper bits for narrow mode.
   function automatic logic [rita_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 999));
         2: return '1;
         3: return 64'd1 << $urandom_range(0, 63);
         4: return {32'($urandom), 32'hFFFF_FFFF};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one number after a random gap and hold it until the block takes it.
   // Valid is only lowered when a gap is drawn, so a back-to-back item keeps
   // valid high across the boundary.
   task automatic push_number(input logic [rita_pkg::VALUE_W-1:0] value,
                              input logic [rita_pkg::RADIX_W-1:0] radix,
                              input logic                         wide);
      int gap;
      if ($urandom_range(0, 15) == 0) calm_send = !calm_send;
      gap = draw_gap(calm_send);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.value     <= value;
      req_ch.radix     <= radix;
      req_ch.wide_mode <= wide;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      numbers_sent++;
      if (radix < rita_pkg::RADIX_BIN || radix > rita_pkg::RADIX_HEX) numbers_rejected++;
   endtask

   // Drop valid and hold off until every predicted character has arrived.
   task automatic drain_wait();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (chars_outstanding != 0) @(negedge clock);
   endtask

   // Response side: draw a stall per character, then accept one.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) calm_recv = !calm_recv;
         gap = draw_gap(calm_recv);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int                           sel;
      logic [rita_pkg::RADIX_W-1:0] radix;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.value     <= '0;
      req_ch.radix     <= '0;
      req_ch.wide_mode <= 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: fixed-width hex and binary at the value extremes, the upper
      // half ignored in narrow mode, zero in the division path, the longest
      // division (radix 3, all ones), and every kind of rejected radix.
      push_number('1,                      rita_pkg::RADIX_HEX, 1'b1);
      push_number('0,                      rita_pkg::RADIX_HEX, 1'b1);
      push_number(64'hDEAD_BEEF_1234_5678, rita_pkg::RADIX_HEX, 1'b0);
      push_number(64'h0123_4567_89AB_CDEF, rita_pkg::RADIX_HEX, 1'b1);
      push_number('1,                      rita_pkg::RADIX_BIN, 1'b1);
      push_number('0,                      rita_pkg::RADIX_BIN, 1'b0);
      push_number(64'h8000_0000_0000_0001, rita_pkg::RADIX_BIN, 1'b1);
      push_number('0,                      8'd10,     1'b1);
      push_number(64'hFFFF_FFFF_0000_0000, 8'd10,     1'b0);
      push_number('1,                      8'd10,     1'b1);
      push_number('1,                      8'd3,      1'b1);
      push_number('1,                      8'd3,      1'b0);
      push_number('1,                      8'd15,     1'b1);
      push_number(64'd48_879,              8'd4,      1'b1);
      push_number(64'd511,                 8'd8,      1'b0);
      push_number(64'd1,                   8'd9,      1'b1);
      push_number(64'h7FFF_FFFF_FFFF_FFFF, 8'd11,     1'b1);
      push_number(64'd123_456_789,         8'd12,     1'b0);
      push_number(64'd168,                 8'd13,     1'b1);
      push_number(64'd195,                 8'd14,     1'b0);
      push_number(64'd5,                   8'd0,      1'b1);
      push_number(64'd5,                   8'd1,      1'b0);
      push_number(64'd5,                   8'd17,     1'b1);
      push_number(64'd5,                   8'd255,    1'b0);
      push_number(64'd6,                   8'd7,      1'b1);
      drain_wait();

      // Random: mostly valid radices with mixed value shapes, some rejected
      // radices as noise. Drain now and then so the sender also sits idle
      // with nothing in flight.
      while (numbers_sent < 140) begin
         sel = $urandom_range(0, 19);
         if (sel == 0)
            radix = 8'($urandom_range(0, 1));
         else if (sel == 1)
            radix = 8'($urandom_range(17, 255));
         else if (sel < 5)
            radix = rita_pkg::RADIX_BIN;
         else if (sel < 8)
            radix = rita_pkg::RADIX_HEX;
         else
            radix = 8'($urandom_range(3, 15));
         push_number(random_value(), radix, 1'($urandom_range(0, 1)));
         if (radix >= rita_pkg::RADIX_BIN && radix <= rita_pkg::RADIX_HEX) begin
            random_converted++;
            if (random_converted % 35 == 0) drain_wait();
         end
      end

      // Wait for the tail, then give stray characters time to show up.
      drain_wait();
      repeat (200) @(posedge clock);

      $display("Converted %0d numbers (%0d with an out-of-range radix) across radices 2-16,",
               numbers_sent, numbers_rejected);
      $display("both widths and random stalls; %0d characters compared.", chars_seen);
      if (mismatch_count == 0 && chars_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
rtl/core/rita_pkg.sv
rtl/core/rita_if.sv
rtl/core/rita_dp.sv
rtl/core/rita_ctrl.sv
rtl/core/radix_integer_to_ascii.sv
tb/sv/rita_char_checker.sv
tb/sv/tb_top.sv
